FILE: src/gather_dequant_u8_embedding_core_defines.svh
// Assertion macros shared by the embedding gather RTL.
`ifndef GATHER_DEQUANT_U8_EMBEDDING_CORE_DEFINES_SVH
`define GATHER_DEQUANT_U8_EMBEDDING_CORE_DEFINES_SVH

// Concurrent check on the rising edge of clk, masked while rst_n is low.
`define GDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising edge of clk that also holds during reset.
`define GDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/gdq_u8_pkg.sv
// Shared constants and types for the u8 embedding gather with dequantisation.
`timescale 1ns / 1ps

package gdq_u8_pkg;

    localparam int DEF_MAX_ROWS     = 1024;
    localparam int DEF_MAX_FEATURES = 64;

    // Input item kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_PAIR   = 2'd1;
    localparam logic [1:0] KIND_GATHER = 2'd2;

    // Register indexes on the APB port (byte address 4*i)
    localparam logic [1:0] REG_FEATURE_COUNT = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT     = 2'd1;
    localparam logic [1:0] REG_REVERSE       = 2'd2;

    localparam logic [6:0]  FEATURE_COUNT_RST = 7'd64;
    localparam logic [10:0] ROW_COUNT_RST     = 11'd1024;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

FILE: src/gather_dequant_u8_embedding_core.sv
// Top level: u8 embedding table gather with per-row Q8.8 zero point and Q8.24 scale.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid/in_ready) carries one item per transfer. Kind byte
//   writes one table byte, kind pair writes a row's zero point and scale; both
//   finish in the transfer cycle and give no result. Kind gather looks up a
//   signed row index (reverse mode adds row_count to a negative index) and
//   emits feature_count results on the output channel (out_valid/out_ready),
//   feature_position counting up from 0 and last on the final one. A bad index
//   gives a single result with index_error and last set and value zero.
//   Timing: a gather holds the input side while the table read port issues
//   one feature address per cycle unless the output stalls. Results go
//   through read, multiply, then round/saturate into the output register
//   and follow one per cycle unless the output stalls; an index fault
//   enters the same pipeline without a table read.
//   A stall on out_ready freezes the whole read pipeline and the input side;
//   nothing is dropped. Reset (rst_n low, asynchronous) empties the pipeline
//   and restores feature_count 64, row_count 1024 and normal indexing; table
//   contents are not cleared and must be written before being gathered.
//   Write the registers over the APB port only while the block is idle; the block itself does not enforce it.

`include "gather_dequant_u8_embedding_core_defines.svh"

module gather_dequant_u8_embedding_core #(
    parameter int MAX_ROWS     = gdq_u8_pkg::DEF_MAX_ROWS,
    parameter int MAX_FEATURES = gdq_u8_pkg::DEF_MAX_FEATURES
) (
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input items
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic [9:0]          row,
    input  logic [5:0]          column,
    input  logic [7:0]          byte_value,
    input  logic signed [15:0]  zero_point,
    input  logic signed [31:0]  scale,
    input  logic signed [10:0]  index,
    // result items
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  value,
    output logic [5:0]          feature_position,
    output logic                last,
    output logic                index_error
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int COL_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int TBL_DEPTH = MAX_ROWS * (1 << COL_W);
    localparam logic [6:0]  NF_MAX   = 7'(MAX_FEATURES);
    localparam logic [17:0] ROWS_MAX = 18'(MAX_ROWS);

    // configuration registers
    logic [6:0]  feature_count_reg;
    logic [10:0] row_count_reg;
    logic        reverse_reg;

    gdq_u8_pkg::state_t state_reg, state_next;
    logic [RW-1:0]      row_sel_reg;
    logic [COL_W-1:0]   f_reg;

    // memories
    logic [7:0]  tbl_mem [TBL_DEPTH];
    logic [47:0] pair_mem [MAX_ROWS];
    logic [7:0]  tbl_rdata_reg;
    logic [47:0] pair_rdata_reg;

    // pipeline stages
    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_pos_reg;
    logic               s1_last_reg;
    logic               s1_err_reg;
    logic               s2_valid_reg;
    logic signed [49:0] s2_prod_reg;
    logic [COL_W-1:0]   s2_pos_reg;
    logic               s2_last_reg;
    logic               s2_err_reg;
    logic               out_valid_reg;
    logic signed [31:0] value_reg;
    logic [5:0]         pos_reg;
    logic               last_reg;
    logic               err_reg;

    logic               adv;
    logic               in_xfer;
    logic               cfg_wr;
    logic [6:0]         nf;
    logic [6:0]         nf_last;
    logic               issue;
    logic               issue_last;
    logic [16:0]        row_x;
    logic               load_row_ok;
    logic               tbl_we;
    logic               pair_we;
    logic               gather_go;
    logic signed [17:0] idx_x;
    logic signed [17:0] adj;
    logic               idx_bad;
    logic [17:0]        rows_eff;
    logic signed [17:0] d;
    logic signed [49:0] prod;
    logic signed [50:0] rnd;
    logic signed [34:0] q;
    logic signed [31:0] sat;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_count_reg <= gdq_u8_pkg::FEATURE_COUNT_RST;
            row_count_reg     <= gdq_u8_pkg::ROW_COUNT_RST;
            reverse_reg       <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                gdq_u8_pkg::REG_FEATURE_COUNT: feature_count_reg <= pwdata[6:0];
                gdq_u8_pkg::REG_ROW_COUNT:     row_count_reg     <= pwdata[10:0];
                gdq_u8_pkg::REG_REVERSE:       reverse_reg       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gdq_u8_pkg::REG_FEATURE_COUNT: prdata = {25'd0, feature_count_reg};
            gdq_u8_pkg::REG_ROW_COUNT:     prdata = {21'd0, row_count_reg};
            gdq_u8_pkg::REG_REVERSE:       prdata = {31'd0, reverse_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    // ---------------- intake and index check ----------------
    // Whole pipeline moves together; hold everything while the output stalls.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == gdq_u8_pkg::ST_IDLE) && adv;
    assign in_xfer  = in_valid && in_ready;

    assign row_x       = {7'd0, row};
    assign load_row_ok = (row_x < 17'(MAX_ROWS));
    assign tbl_we      = in_xfer && (kind == gdq_u8_pkg::KIND_BYTE) && load_row_ok
                         && ({1'b0, column} < NF_MAX);
    assign pair_we     = in_xfer && (kind == gdq_u8_pkg::KIND_PAIR) && load_row_ok;
    assign gather_go   = in_xfer && (kind == gdq_u8_pkg::KIND_GATHER);

    assign rows_eff = ({7'd0, row_count_reg} > ROWS_MAX) ? ROWS_MAX : {7'd0, row_count_reg};
    assign idx_x    = {{7{index[10]}}, index};
    assign adj      = (index[10] && reverse_reg) ? idx_x + $signed({7'd0, row_count_reg})
                                                 : idx_x;
    assign idx_bad  = (index[10] && !reverse_reg) || adj[17]
                      || ($unsigned(adj) >= rows_eff);

    always_comb
    begin
        if (feature_count_reg == 7'd0)
            nf = 7'd1;
        else if (feature_count_reg > NF_MAX)
            nf = NF_MAX;
        else
            nf = feature_count_reg;
    end
    assign nf_last    = nf - 7'd1;
    assign issue      = (state_reg == gdq_u8_pkg::ST_RUN) && adv;
    assign issue_last = (7'(f_reg) == nf_last);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gdq_u8_pkg::ST_IDLE:
                if (gather_go && !idx_bad)
                    state_next = gdq_u8_pkg::ST_RUN;
            gdq_u8_pkg::ST_RUN:
                if (issue && issue_last)
                    state_next = gdq_u8_pkg::ST_IDLE;
            default:
                state_next = gdq_u8_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdq_u8_pkg::ST_IDLE;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (adv)
            begin
                s1_valid_reg  <= issue || (gather_go && idx_bad);
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[{row_x[RW-1:0], column[COL_W-1:0]}] <= byte_value;
        if (issue)
            tbl_rdata_reg <= tbl_mem[{row_sel_reg, f_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (pair_we)
            pair_mem[row_x[RW-1:0]] <= {zero_point, scale};
        if (issue)
            pair_rdata_reg <= pair_mem[row_sel_reg];
    end

    // ---------------- datapath ----------------
    assign d    = $signed({2'b00, tbl_rdata_reg, 8'h00})
                  - $signed({{2{pair_rdata_reg[47]}}, pair_rdata_reg[47:32]});
    assign prod = 50'(d) * 50'($signed(pair_rdata_reg[31:0]));

    // Round half up, then floor shift to Q16.16.
    assign rnd = 51'(s2_prod_reg) + 51'sd32768;
    assign q   = rnd[50:16];
    always_comb
    begin
        if (!q[34] && (q[33:31] != 3'b000))
            sat = 32'sh7FFF_FFFF;
        else if (q[34] && (q[33:31] != 3'b111))
            sat = 32'sh8000_0000;
        else
            sat = q[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (gather_go && !idx_bad)
        begin
            row_sel_reg <= adj[RW-1:0];
            f_reg       <= '0;
        end
        else if (issue)
            f_reg <= f_reg + COL_W'(1);

        if (adv)
        begin
            // stage 1: read issue or an index fault
            s1_pos_reg  <= issue ? f_reg : '0;
            s1_last_reg <= issue ? issue_last : 1'b1;
            s1_err_reg  <= !issue;
            // stage 2: product
            s2_prod_reg <= prod;
            s2_pos_reg  <= s1_pos_reg;
            s2_last_reg <= s1_last_reg;
            s2_err_reg  <= s1_err_reg;
            // output register
            value_reg   <= s2_err_reg ? 32'sd0 : sat;
            pos_reg     <= 6'(s2_pos_reg);
            last_reg    <= s2_last_reg;
            err_reg     <= s2_err_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign value            = value_reg;
    assign feature_position = pos_reg;
    assign last             = last_reg;
    assign index_error      = err_reg;

    // ---------------- checks ----------------
    `GDQ_ASSERT(a_err_result, (out_valid && index_error) |-> (last && value == 32'sd0 && feature_position == 6'd0), "index fault result not a lone zero")
    `GDQ_ASSERT(a_last_pos, (out_valid && last && !index_error) |-> (7'(feature_position) == nf_last), "last flag at wrong feature")
    `GDQ_ASSERT(a_run_blocks, (state_reg == gdq_u8_pkg::ST_RUN) |-> !in_ready, "intake open during a gather")
    `GDQ_ASSERT(a_gather_starts, (gather_go && !idx_bad) |=> (state_reg == gdq_u8_pkg::ST_RUN), "gather did not start issuing")
    `GDQ_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "result presented during reset")

endmodule

FILE: tb/gdq_gather_checker.sv
// Checker for the u8 embedding gather: tracks loads and registers, predicts and compares results.
`timescale 1ns / 1ps

module gdq_gather_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [9:0]         row,
    input  logic [5:0]         column,
    input  logic [7:0]         byte_value,
    input  logic signed [15:0] zero_point,
    input  logic signed [31:0] scale,
    input  logic signed [10:0] index,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] value,
    input  logic [5:0]         feature_position,
    input  logic               last,
    input  logic               index_error,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         position;
        logic               last;
        logic               error;
    } feature_result_t;

    logic [7:0]         emb_bytes [0:gdq_u8_pkg::DEF_MAX_ROWS*gdq_u8_pkg::DEF_MAX_FEATURES-1];
    logic signed [15:0] row_zp    [0:gdq_u8_pkg::DEF_MAX_ROWS-1];
    logic signed [31:0] row_scale [0:gdq_u8_pkg::DEF_MAX_ROWS-1];

    logic [6:0]  feature_count_q;
    logic [10:0] row_count_q;
    logic        reverse_q;

    feature_result_t expected_results [$];

    // (byte*256 - zp) * scale in Q.32, rounded half up to Q16.16 and saturated
    function automatic logic signed [31:0] dequantise(input logic [7:0] b,
                                                      input logic signed [15:0] zp,
                                                      input logic signed [31:0] sc);
        logic signed [17:0] diff;
        logic signed [49:0] prod;
        logic signed [33:0] quot;
        diff = $signed({2'b00, b, 8'h00}) - zp;
        prod = diff * sc + 50'sd32768;
        quot = prod >>> 16;
        if (quot > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        if (quot < -34'sd2147483648)
            return 32'sh80000000;
        return quot[31:0];
    endfunction

    task automatic predict_gather(input logic signed [10:0] idx_in);
        int              idx;
        int              rows;
        int              nf;
        bit              bad;
        feature_result_t res;
        idx  = idx_in;
        rows = (row_count_q > gdq_u8_pkg::DEF_MAX_ROWS) ? gdq_u8_pkg::DEF_MAX_ROWS
                                                        : int'(row_count_q);
        if (feature_count_q == 0)
            nf = 1;
        else if (feature_count_q > gdq_u8_pkg::DEF_MAX_FEATURES)
            nf = gdq_u8_pkg::DEF_MAX_FEATURES;
        else
            nf = feature_count_q;
        bad = 1'b0;
        // adjust with the raw register, bound with the saturated one
        if (idx < 0)
        begin
            if (reverse_q)
                idx = idx + int'(row_count_q);
            else
                bad = 1'b1;
        end
        if (idx < 0 || idx >= rows)
            bad = 1'b1;
        if (bad)
        begin
            res = '{value: 32'sd0, position: 6'd0, last: 1'b1, error: 1'b1};
            expected_results.push_back(res);
        end
        else
        begin
            for (int f = 0; f < nf; f++)
            begin
                res.value    = dequantise(emb_bytes[idx*gdq_u8_pkg::DEF_MAX_FEATURES + f],
                                          row_zp[idx], row_scale[idx]);
                res.position = 6'(f);
                res.last     = (f == nf - 1);
                res.error    = 1'b0;
                expected_results.push_back(res);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        feature_result_t want;
        if (!rst_n)
        begin
            feature_count_q = gdq_u8_pkg::FEATURE_COUNT_RST;
            row_count_q     = gdq_u8_pkg::ROW_COUNT_RST;
            reverse_q       = 1'b0;
            expected_results.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            // compare before taking a new gather so an early result cannot match it
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: value %0d pos %0d last %0b err %0b",
                                 value, feature_position, last, index_error);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.value !== value || want.position !== feature_position ||
                        want.last !== last || want.error !== index_error)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result mismatch: expected value %0d pos %0d last %0b ",
                                      "err %0b, got value %0d pos %0d last %0b err %0b"},
                                     want.value, want.position, want.last, want.error,
                                     value, feature_position, last, index_error);
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    gdq_u8_pkg::REG_FEATURE_COUNT: feature_count_q = pwdata[6:0];
                    gdq_u8_pkg::REG_ROW_COUNT:     row_count_q     = pwdata[10:0];
                    gdq_u8_pkg::REG_REVERSE:       reverse_q       = pwdata[0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                case (kind)
                    gdq_u8_pkg::KIND_BYTE:   emb_bytes[{row, column}] = byte_value;
                    gdq_u8_pkg::KIND_PAIR:
                    begin
                        row_zp[row]    = zero_point;
                        row_scale[row] = scale;
                    end
                    gdq_u8_pkg::KIND_GATHER: predict_gather(index);
                    default: ;
                endcase
            end

            pending = expected_results.size();
        end
    end

endmodule

FILE: tb/tb_gather_dequant_u8_embedding_core.sv
// Testbench top for the u8 embedding gather: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_gather_dequant_u8_embedding_core;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         kind = '0;
    logic [9:0]         row = '0;
    logic [5:0]         column = '0;
    logic [7:0]         byte_value = '0;
    logic signed [15:0] zero_point = '0;
    logic signed [31:0] scale = '0;
    logic signed [10:0] index = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] value;
    logic [5:0]         feature_position;
    logic               last;
    logic               index_error;

    int fail_count;
    int pending;

    int  cycle_no = 0;
    logic calm;
    bit  squeeze_req = 1'b0;

    // stimulus-side view of what has been written, so no gather reads a blank entry
    logic [63:0] cols_done [0:gdq_u8_pkg::DEF_MAX_ROWS-1];
    bit          pair_done [0:gdq_u8_pkg::DEF_MAX_ROWS-1];
    int          loaded_rows [$];
    int          items_sent = 0;
    int          fc_reg = gdq_u8_pkg::FEATURE_COUNT_RST;
    int          rc_reg = gdq_u8_pkg::ROW_COUNT_RST;
    bit          rev_reg = 1'b0;

    int phase_fc  [7] = '{64, 1, 0, 127, 5, 3, 16};
    int phase_rc  [7] = '{1024, 1, 0, 2047, 37, 1000, 613};
    bit phase_rev [7] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    gather_dequant_u8_embedding_core uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .row(row),
        .column(column), .byte_value(byte_value), .zero_point(zero_point),
        .scale(scale), .index(index),
        .out_valid(out_valid), .out_ready(out_ready), .value(value),
        .feature_position(feature_position), .last(last), .index_error(index_error)
    );

    gdq_gather_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .row(row),
        .column(column), .byte_value(byte_value), .zero_point(zero_point),
        .scale(scale), .index(index),
        .out_valid(out_valid), .out_ready(out_ready), .value(value),
        .feature_position(feature_position), .last(last), .index_error(index_error),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_no <= cycle_no + 1;

    // no idling on either side inside this window
    assign calm = (cycle_no >= 1500 && cycle_no < 3000);

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    initial
    begin
        bit squeezed;
        squeezed = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req && !squeezed)
            begin
                squeezed = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    function automatic int nf_eff();
        if (fc_reg == 0)
            return 1;
        return (fc_reg > gdq_u8_pkg::DEF_MAX_FEATURES) ? gdq_u8_pkg::DEF_MAX_FEATURES : fc_reg;
    endfunction

    function automatic int rows_eff();
        return (rc_reg > gdq_u8_pkg::DEF_MAX_ROWS) ? gdq_u8_pkg::DEF_MAX_ROWS : rc_reg;
    endfunction

    function automatic bit row_ready(input int r);
        logic [63:0] mask;
        mask = (nf_eff() == 64) ? '1 : ((64'd1 << nf_eff()) - 64'd1);
        return pair_done[r] && ((cols_done[r] & mask) == mask);
    endfunction

    // row a gather index lands on, or -1 for an index error
    function automatic int target_row(input int idx);
        int t;
        t = idx;
        if (t < 0)
        begin
            if (!rev_reg)
                return -1;
            t = t + rc_reg;
        end
        if (t < 0 || t >= rows_eff())
            return -1;
        return t;
    endfunction

    function automatic int pick_zp();
        case ($urandom_range(3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int pick_scale();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h01000000;
            3: return int'($urandom_range(65535)) - 32768;
            default: return $urandom;
        endcase
    endfunction

    // offer one item at the falling edge and hold it until the transfer
    task automatic send_item(input logic [1:0] k, input int r, input int c, input int b,
                             input int zp, input int sc, input int idx);
        while (!calm && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        row        <= 10'(r);
        column     <= 6'(c);
        byte_value <= 8'(b);
        zero_point <= 16'(zp);
        scale      <= 32'(sc);
        index      <= 11'(idx);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (k == gdq_u8_pkg::KIND_BYTE)
            cols_done[10'(r)][6'(c)] = 1'b1;
        else if (k == gdq_u8_pkg::KIND_PAIR)
            pair_done[10'(r)] = 1'b1;
        if (k != KIND_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input int r, input int c, input int b);
        send_item(gdq_u8_pkg::KIND_BYTE, r, c, b, $urandom, $urandom, $urandom);
    endtask

    task automatic send_pair(input int r, input int zp, input int sc);
        send_item(gdq_u8_pkg::KIND_PAIR, r, $urandom, $urandom, zp, sc, $urandom);
    endtask

    task automatic send_gather(input int idx);
        send_item(gdq_u8_pkg::KIND_GATHER, $urandom, $urandom, $urandom, $urandom, $urandom,
                  idx);
    endtask

    task automatic load_row(input int r);
        int nf;
        nf = nf_eff();
        send_pair(r, pick_zp(), pick_scale());
        for (int f = 0; f < nf; f++)
            send_byte(r, f, $urandom_range(255));
        loaded_rows.push_back(r);
    endtask

    // gather a row that is fully written, loading a fresh one if none is at hand
    task automatic gather_known_row();
        int r;
        int idx;
        bit found;
        found = 1'b0;
        r = 0;
        for (int tries = 0; tries < 8 && !found && loaded_rows.size() > 0; tries++)
        begin
            r = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
            if (r < rows_eff() && row_ready(r))
                found = 1'b1;
        end
        if (!found && rows_eff() > 0)
        begin
            r = $urandom_range(rows_eff() - 1);
            load_row(r);
            found = 1'b1;
        end
        if (!found)
            idx = int'($urandom_range(2047)) - 1024;
        else
        begin
            idx = r;
            if (rev_reg && r - rc_reg >= -1024 && $urandom_range(1))
                idx = r - rc_reg;
        end
        send_gather(idx);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // upper bits of each write carry junk that the block must drop
    task automatic set_config(input int fc, input int rc, input bit rev);
        settle();
        write_reg(gdq_u8_pkg::REG_FEATURE_COUNT, (32'($urandom) & ~32'h7F) | 32'(fc));
        write_reg(gdq_u8_pkg::REG_ROW_COUNT, (32'($urandom) & ~32'h7FF) | 32'(rc));
        write_reg(gdq_u8_pkg::REG_REVERSE, (32'($urandom) & ~32'h1) | 32'(rev));
        fc_reg  = fc;
        rc_reg  = rc;
        rev_reg = rev;
    endtask

    initial
    begin
        int roll;
        int idx;
        int t;
        int phase_end;
        rst_n <= 1'b0;
        for (int r = 0; r < gdq_u8_pkg::DEF_MAX_ROWS; r++)
        begin
            cols_done[r] = '0;
            pair_done[r] = 1'b0;
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: reset settings, unused kind, negative indices without reverse mode
        send_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_gather(-1);
        send_gather(-1024);

        // directed: positive saturation and rounding ties at two features
        set_config(2, 1024, 1'b0);
        send_pair(0, -32768, 32'h7FFFFFFF);
        send_byte(0, 0, 255);
        send_byte(0, 1, 0);
        send_pair(1023, 32767, 32'h80000000);
        send_byte(1023, 0, 0);
        send_byte(1023, 1, 255);
        send_pair(5, 1, 32768);
        send_byte(5, 0, 0);
        send_byte(5, 1, 255);
        send_pair(6, -1, 32768);
        send_byte(6, 0, 0);
        send_byte(6, 1, 1);
        loaded_rows = '{0, 1023, 5, 6};
        send_gather(0);
        send_gather(1023);
        send_gather(5);
        send_gather(6);

        // directed: reverse mode at full and at a small row count
        set_config(2, 1024, 1'b1);
        send_gather(-1);
        send_gather(-1024);
        set_config(2, 7, 1'b1);
        send_gather(6);
        send_gather(7);
        send_gather(-1);
        send_gather(-8);

        for (int ph = 0; ph < 7; ph++)
        begin
            set_config(phase_fc[ph], phase_rc[ph], phase_rev[ph]);
            if (ph == 3)
                squeeze_req = 1'b1;
            phase_end = items_sent + 62;
            while (items_sent < phase_end)
            begin
                roll = $urandom_range(99);
                if (roll < 45)
                begin
                    load_row(rows_eff() > 0 ? $urandom_range(rows_eff() - 1)
                                            : $urandom_range(gdq_u8_pkg::DEF_MAX_ROWS - 1));
                    repeat ($urandom_range(1, 3)) gather_known_row();
                end
                else if (roll < 72)
                    gather_known_row();
                else if (roll < 86)
                begin
                    // any index; steer away from rows that are not fully written
                    idx = int'($urandom_range(2047)) - 1024;
                    t = target_row(idx);
                    if (t >= 0 && !row_ready(t))
                        gather_known_row();
                    else
                        send_gather(idx);
                end
                else if (roll < 93)
                    send_byte($urandom_range(gdq_u8_pkg::DEF_MAX_ROWS - 1), $urandom_range(63),
                              $urandom_range(255));
                else if (roll < 97)
                    send_pair($urandom_range(gdq_u8_pkg::DEF_MAX_ROWS - 1), pick_zp(),
                              pick_scale());
                else
                    send_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: gather_dequant_u8_embedding_core.f
+incdir+src
src/gdq_u8_pkg.sv
src/gather_dequant_u8_embedding_core.sv
tb/gdq_gather_checker.sv
tb/tb_gather_dequant_u8_embedding_core.sv
